>>> sv/bpd_pkg.sv
// Shared constants, types and helper functions for the byte decryption interpreter.
package bpd_pkg;

	localparam int WINDOW_BYTES = 48;
	localparam int JUMP_BUDGET  = 100000000;
	localparam int JUMPS_W      = 27;
	localparam int PROG_WORDS   = 7;
	localparam int RAM_DEPTH    = 8;
	localparam int RAM_AW       = 3;
	localparam int WORD_W       = 64;
	localparam int ADDR_W       = 6;
	localparam int PC_W         = 6;
	localparam int PCX_W        = 9;

	localparam logic [RAM_AW-1:0] START_COUNT_IDX = 3'd7;

	localparam logic [7:0] OP_JMP     = 8'hEB;
	localparam logic [7:0] OP_DEC     = 8'hFE;
	localparam logic [7:0] OP_SUB_CL  = 8'h2A;
	localparam logic [7:0] OP_ADD_CL  = 8'h02;
	localparam logic [7:0] OP_XOR_CL  = 8'h32;
	localparam logic [7:0] OP_ADD_IMM = 8'h04;
	localparam logic [7:0] OP_SUB_IMM = 8'h2C;
	localparam logic [7:0] OP_XOR_IMM = 8'h34;
	localparam logic [7:0] OP_ROT_IMM = 8'hC0;
	localparam logic [7:0] OP_ROT_CL  = 8'hD2;
	localparam logic [7:0] OP_NOP     = 8'h90;
	localparam logic [7:0] OP_CLC     = 8'hF8;
	localparam logic [7:0] OP_STC     = 8'hF9;
	localparam logic [7:0] MODRM_ROL  = 8'hC0;
	localparam logic [7:0] MODRM_ROR  = 8'hC8;

	localparam logic [1:0] ERR_NONE   = 2'd0;
	localparam logic [1:0] ERR_OPCODE = 2'd1;
	localparam logic [1:0] ERR_JUMPS  = 2'd2;

	// Two consecutive program words: every instruction fits in them.
	typedef struct packed {
		logic [WORD_W-1:0] hi;
		logic [WORD_W-1:0] lo;
	} fetch_t;

	function automatic logic [7:0] rotl8(input logic [7:0] v, input logic [2:0] n);
		logic [15:0] w;
		begin
			w = {v, v} << n;
			rotl8 = w[15:8];
		end
	endfunction

	function automatic logic [7:0] rotr8(input logic [7:0] v, input logic [2:0] n);
		logic [15:0] w;
		begin
			w = {v, v} >> n;
			rotr8 = w[7:0];
		end
	endfunction

endpackage

>>> sv/bpd_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module bpd_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> sv/bpd_prog_store.sv
// Program store: APB register file and the program RAM copies read by the engine.
module bpd_prog_store (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [bpd_pkg::ADDR_W-1:0] paddr,
	input  logic [bpd_pkg::WORD_W-1:0] pwdata,
	output logic [bpd_pkg::WORD_W-1:0] prdata,
	input  logic [bpd_pkg::RAM_AW-1:0] fetch_addr,
	output bpd_pkg::fetch_t            fetch,
	output logic [7:0]                 start_count
);
	import bpd_pkg::*;

	logic                 cfg_wr;
	logic [RAM_AW-1:0]    cfg_idx;
	logic                 prog_we;
	logic [RAM_AW-1:0]    fetch_addr_hi;
	logic [RAM_DEPTH-1:0] valid_q;
	logic [7:0]           start_count_q;
	logic                 vld_lo_q;
	logic                 vld_hi_q;
	logic [RAM_AW-1:0]    rd_idx_q;
	logic [WORD_W-1:0]    lo_rdata;
	logic [WORD_W-1:0]    hi_rdata;
	logic [WORD_W-1:0]    bus_rdata;

	assign cfg_wr        = psel & penable & pwrite;
	assign cfg_idx       = paddr[ADDR_W-1:3];
	assign prog_we       = cfg_wr & (cfg_idx != START_COUNT_IDX);
	assign fetch_addr_hi = fetch_addr + RAM_AW'(1);

	// Three identical copies: low word, next word, and one for bus reads.
	bpd_ram #(.WIDTH(WORD_W), .DEPTH(RAM_DEPTH)) u_ram_lo (
		.clk  (clk),
		.we   (prog_we),
		.waddr(cfg_idx),
		.wdata(pwdata),
		.raddr(fetch_addr),
		.rdata(lo_rdata)
	);

	bpd_ram #(.WIDTH(WORD_W), .DEPTH(RAM_DEPTH)) u_ram_hi (
		.clk  (clk),
		.we   (prog_we),
		.waddr(cfg_idx),
		.wdata(pwdata),
		.raddr(fetch_addr_hi),
		.rdata(hi_rdata)
	);

	bpd_ram #(.WIDTH(WORD_W), .DEPTH(RAM_DEPTH)) u_ram_bus (
		.clk  (clk),
		.we   (prog_we),
		.waddr(cfg_idx),
		.wdata(pwdata),
		.raddr(cfg_idx),
		.rdata(bus_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q       <= '0;
			start_count_q <= '0;
			vld_lo_q      <= 1'b0;
			vld_hi_q      <= 1'b0;
			rd_idx_q      <= '0;
		end else begin
			if (prog_we) begin
				valid_q[cfg_idx] <= 1'b1;
			end
			if (cfg_wr && cfg_idx == START_COUNT_IDX) begin
				start_count_q <= pwdata[7:0];
			end
			vld_lo_q <= valid_q[fetch_addr];
			vld_hi_q <= valid_q[fetch_addr_hi];
			rd_idx_q <= cfg_idx;
		end
	end

	// Words never written read as zero, which is their reset value.
	assign fetch.lo    = vld_lo_q ? lo_rdata : '0;
	assign fetch.hi    = vld_hi_q ? hi_rdata : '0;
	assign start_count = start_count_q;

	always_comb begin
		if (rd_idx_q == START_COUNT_IDX) begin
			prdata = WORD_W'(start_count_q);
		end else if (valid_q[rd_idx_q]) begin
			prdata = bus_rdata;
		end else begin
			prdata = '0;
		end
	end

endmodule

>>> sv/bpd_engine.sv
// Instruction sequencer: runs the program on one byte, one instruction per cycle.
module bpd_engine (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       start_run,
	input  logic [7:0]                 data_byte,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [7:0]                 plain_byte,
	output logic [1:0]                 status,
	output logic [bpd_pkg::RAM_AW-1:0] fetch_addr,
	input  bpd_pkg::fetch_t            fetch,
	input  logic [7:0]                 start_count
);
	import bpd_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_FIN  = 2'd2;

	logic [1:0]         state_q;
	logic [PC_W-1:0]    pc_q;
	logic [7:0]         acc_q;
	logic [7:0]         cnt_q;
	logic [JUMPS_W-1:0] jumps_q;
	logic [1:0]         err_q;
	logic               out_valid_q;
	logic [7:0]         plain_q;
	logic [1:0]         status_q;

	logic               accept;
	logic               out_free;
	logic [2*WORD_W-1:0] win;
	logic [7:0]         op;
	logic [7:0]         b1;
	logic [7:0]         b2;
	logic [7:0]         acc_n;
	logic [1:0]         adv;
	logic               is_jump;
	logic               bad_op;
	logic               jump_dead;
	logic [PCX_W-1:0]   pc_n;
	logic               leave;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid & ~in_stall;
	assign out_free = ~out_valid_q | ~out_stall;

	always_comb begin
		win = {fetch.hi, fetch.lo} >> {pc_q[2:0], 3'b000};
		op  = win[7:0];
		b1  = win[15:8];
		b2  = win[23:16];
	end

	always_comb begin
		acc_n   = acc_q;
		adv     = 2'd0;
		is_jump = 1'b0;
		bad_op  = 1'b0;
		case (op)
			OP_JMP: begin
				is_jump = 1'b1;
			end
			OP_DEC: begin
				acc_n = acc_q - 8'd1;
				adv   = 2'd2;
			end
			OP_SUB_CL: begin
				acc_n = acc_q - cnt_q;
				adv   = 2'd2;
			end
			OP_ADD_CL: begin
				acc_n = acc_q + cnt_q;
				adv   = 2'd2;
			end
			OP_XOR_CL: begin
				acc_n = acc_q ^ cnt_q;
				adv   = 2'd2;
			end
			OP_ADD_IMM: begin
				acc_n = acc_q + b1;
				adv   = 2'd2;
			end
			OP_SUB_IMM: begin
				acc_n = acc_q - b1;
				adv   = 2'd2;
			end
			OP_XOR_IMM: begin
				acc_n = acc_q ^ b1;
				adv   = 2'd2;
			end
			OP_ROT_IMM: begin
				acc_n = (b1 == MODRM_ROL) ? rotl8(acc_q, b2[2:0]) : rotr8(acc_q, b2[2:0]);
				adv   = 2'd3;
			end
			OP_ROT_CL: begin
				acc_n = (b1 == MODRM_ROR) ? rotr8(acc_q, cnt_q[2:0]) : rotl8(acc_q, cnt_q[2:0]);
				adv   = 2'd2;
			end
			OP_NOP, OP_CLC, OP_STC: begin
				adv = 2'd1;
			end
			default: begin
				bad_op = 1'b1;
			end
		endcase
	end

	always_comb begin
		if (is_jump) begin
			pc_n = {3'b000, pc_q} + PCX_W'(2) + {b1[7], b1};
		end else begin
			pc_n = {3'b000, pc_q} + {7'b0, adv};
		end
	end

	// A negative target wraps to a large unsigned value, so one compare covers both ends.
	assign leave     = (pc_n >= PCX_W'(WINDOW_BYTES));
	assign jump_dead = is_jump & (jumps_q == '0);

	// In idle the word holding index 0 is kept ready for the next byte.
	assign fetch_addr = (state_q == S_EXEC) ? pc_n[5:3] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pc_q        <= '0;
			acc_q       <= '0;
			cnt_q       <= '0;
			jumps_q     <= JUMPS_W'(JUMP_BUDGET);
			err_q       <= ERR_NONE;
			out_valid_q <= 1'b0;
			plain_q     <= '0;
			status_q    <= ERR_NONE;
		end else begin
			if (out_valid_q && !out_stall && state_q != S_FIN) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						acc_q <= data_byte;
						pc_q  <= '0;
						if (start_run) begin
							cnt_q   <= start_count;
							jumps_q <= JUMPS_W'(JUMP_BUDGET);
							err_q   <= ERR_NONE;
							state_q <= S_EXEC;
						end else if (err_q != ERR_NONE) begin
							state_q <= S_FIN;
						end else begin
							state_q <= S_EXEC;
						end
					end
				end
				S_EXEC: begin
					if (bad_op) begin
						err_q   <= ERR_OPCODE;
						state_q <= S_FIN;
					end else if (jump_dead) begin
						err_q   <= ERR_JUMPS;
						state_q <= S_FIN;
					end else begin
						acc_q <= acc_n;
						pc_q  <= pc_n[PC_W-1:0];
						if (is_jump) begin
							jumps_q <= jumps_q - JUMPS_W'(1);
						end
						if (leave) begin
							cnt_q   <= cnt_q - 8'd1;
							state_q <= S_FIN;
						end
					end
				end
				S_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						plain_q     <= (err_q != ERR_NONE) ? 8'd0 : acc_q;
						status_q    <= err_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign plain_byte = plain_q;
	assign status     = status_q;

endmodule

>>> sv/byte_poly_decrypt_interpreter.sv
// Top level of the byte decryption interpreter: program store plus sequencer.
// An accepted byte runs its instructions in S_EXEC, then S_FIN registers the result onto
// out_valid (a sticky error skips S_EXEC); S_FIN holds while a waiting result stalls.
// A new byte is accepted only after S_FIN has issued the previous result; the program
// RAM read address of each instruction depends on the previous instruction.
// Reset clears counter, error and output; jump budget reloads; program reads as zero.
module byte_poly_decrypt_interpreter (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       start_run,
	input  logic [7:0]                 data_byte,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [7:0]                 plain_byte,
	output logic [1:0]                 status,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [bpd_pkg::ADDR_W-1:0] paddr,
	input  logic [bpd_pkg::WORD_W-1:0] pwdata,
	output logic [bpd_pkg::WORD_W-1:0] prdata,
	output logic                       pready
);
	import bpd_pkg::*;

	logic [RAM_AW-1:0] fetch_addr;
	fetch_t            fetch;
	logic [7:0]        start_count;

	assign pready = 1'b1;

	bpd_prog_store u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.fetch_addr (fetch_addr),
		.fetch      (fetch),
		.start_count(start_count)
	);

	bpd_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.start_run  (start_run),
		.data_byte  (data_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.plain_byte (plain_byte),
		.status     (status),
		.fetch_addr (fetch_addr),
		.fetch      (fetch),
		.start_count(start_count)
	);

endmodule

>>> sv/bpd_checker.sv
// Port-level checks for the byte decryption interpreter, bound to the top level.
module bpd_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic [7:0]                 plain_byte,
	input logic [1:0]                 status,
	input logic                       pready
);
	import bpd_pkg::*;

	// A stalled result word holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(plain_byte) && $stable(status))
		else $error("stalled result word changed");

	// An error result always carries a zero byte.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ERR_NONE |-> plain_byte == 8'd0)
		else $error("error result with nonzero byte");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status != 2'd3)
		else $error("undefined status code");

	// One word at a time: the input is busy right after an accept.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted twice in a row");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind byte_poly_decrypt_interpreter bpd_checker u_bpd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.plain_byte(plain_byte),
	.status    (status),
	.pready    (pready)
);

>>> test/tb.sv
// Self-checking testbench for the byte decryption interpreter.
module tb;
	import bpd_pkg::*;

	typedef struct packed {
		logic       start;
		logic [7:0] data;
	} byte_item_t;

	typedef struct packed {
		logic [7:0] plain;
		logic [1:0] stat;
	} plain_res_t;

	logic                clk;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic                start_run = 1'b0;
	logic [7:0]          data_byte = 8'h00;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [7:0]          plain_byte;
	logic [1:0]          status;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [ADDR_W-1:0]   paddr = '0;
	logic [WORD_W-1:0]   pwdata = '0;
	logic [WORD_W-1:0]   prdata;
	logic                pready;

	byte_item_t cipher_q[$];
	plain_res_t plain_due[$];
	byte_item_t next_item;
	plain_res_t want;

	// Predictor copy of the block's configuration and state.
	logic [7:0]         prog_mem [0:55];
	logic [7:0]         load_count = 8'h00;
	logic [7:0]         cnt_q = 8'h00;
	logic [JUMPS_W-1:0] jumps_q = JUMPS_W'(JUMP_BUDGET);
	logic [1:0]         err_q = ERR_NONE;

	// Program image being put together before it is written.
	logic [7:0] prog_img [0:55];

	int burst_left = 0;
	int gap_left = 0;
	int stall_mode = 0;
	int stall_span = 0;
	int accepted = 0;
	int checked = 0;
	int mismatches = 0;
	int error_words = 0;
	int programs = 0;

	byte_poly_decrypt_interpreter dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .start_run(start_run), .data_byte(data_byte),
		.out_valid(out_valid), .out_stall(out_stall), .plain_byte(plain_byte), .status(status),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1000000;
		$display("*** FAILED ***");
		$finish;
	end

	function automatic int op_len(input logic [7:0] op);
		case (op)
			OP_NOP, OP_CLC, OP_STC: return 1;
			OP_ROT_IMM: return 3;
			OP_DEC, OP_SUB_CL, OP_ADD_CL, OP_XOR_CL, OP_ADD_IMM, OP_SUB_IMM, OP_XOR_IMM,
			OP_ROT_CL, OP_JMP: return 2;
			default: return 0;
		endcase
	endfunction

	function automatic logic [7:0] spin(input logic [7:0] v, input logic [2:0] n,
			input bit left);
		logic [7:0] r;
		int i;
		r = v;
		for (i = 0; i < n; i++)
			r = left ? {r[6:0], r[7]} : {r[0], r[7:1]};
		return r;
	endfunction

	function automatic plain_res_t decrypt_byte(input byte_item_t it);
		logic [7:0] acc;
		logic [7:0] cl;
		logic [7:0] op;
		logic [7:0] b1;
		logic [7:0] b2;
		int pc;
		plain_res_t r;
		acc = it.data;
		if (it.start) begin
			cnt_q = load_count;
			jumps_q = JUMPS_W'(JUMP_BUDGET);
			err_q = ERR_NONE;
		end
		cl = cnt_q;
		pc = 0;
		while (err_q == ERR_NONE && pc >= 0 && pc < WINDOW_BYTES) begin
			op = prog_mem[pc];
			b1 = prog_mem[pc + 1];
			b2 = prog_mem[pc + 2];
			if (op == OP_JMP) begin
				if (jumps_q == 0) begin
					err_q = ERR_JUMPS;
				end else begin
					jumps_q = jumps_q - 1'b1;
					pc = pc + 2 + int'($signed(b1));
				end
			end else if (op_len(op) == 0) begin
				err_q = ERR_OPCODE;
			end else begin
				case (op)
					OP_DEC: acc = acc - 8'd1;
					OP_SUB_CL: acc = acc - cl;
					OP_ADD_CL: acc = acc + cl;
					OP_XOR_CL: acc = acc ^ cl;
					OP_ADD_IMM: acc = acc + b1;
					OP_SUB_IMM: acc = acc - b1;
					OP_XOR_IMM: acc = acc ^ b1;
					OP_ROT_IMM: acc = spin(acc, b2[2:0], b1 == MODRM_ROL);
					OP_ROT_CL: acc = spin(acc, cl[2:0], b1 != MODRM_ROR);
					default: ;
				endcase
				pc = pc + op_len(op);
			end
		end
		if (err_q != ERR_NONE) begin
			r.plain = 8'h00;
			r.stat = err_q;
		end else begin
			cnt_q = cnt_q - 8'd1;
			r.plain = acc;
			r.stat = ERR_NONE;
		end
		return r;
	endfunction

	// Control flow does not depend on the data, so a revisited index means the
	// program would spin until the jump budget runs out.
	function automatic bit runs_forever();
		bit seen [0:WINDOW_BYTES-1];
		int pc;
		foreach (seen[i]) seen[i] = 1'b0;
		pc = 0;
		while (pc >= 0 && pc < WINDOW_BYTES) begin
			if (seen[pc])
				return 1'b1;
			seen[pc] = 1'b1;
			if (prog_img[pc] == OP_JMP)
				pc = pc + 2 + int'($signed(prog_img[pc + 1]));
			else if (op_len(prog_img[pc]) == 0)
				return 1'b0;
			else
				pc = pc + op_len(prog_img[pc]);
		end
		return 1'b0;
	endfunction

	function automatic logic [7:0] pick_modrm();
		case ($urandom_range(0, 2))
			0: return MODRM_ROL;
			1: return MODRM_ROR;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic write_reg(input int idx, input logic [WORD_W-1:0] val);
		int k;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(idx * 8);
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == START_COUNT_IDX)
			load_count = val[7:0];
		else
			for (k = 0; k < 8; k++) prog_mem[idx * 8 + k] = val[8 * k +: 8];
	endtask

	task automatic load_image(input bit with_count, input logic [7:0] cnt);
		logic [WORD_W-1:0] word;
		int w;
		int k;
		for (w = 0; w < PROG_WORDS; w++) begin
			for (k = 0; k < 8; k++) word[8 * k +: 8] = prog_img[8 * w + k];
			write_reg(w, word);
		end
		if (with_count)
			write_reg(START_COUNT_IDX, {56'd0, cnt});
		programs++;
	endtask

	task automatic queue_byte(input logic start, input logic [7:0] data);
		byte_item_t it;
		it.start = start;
		it.data = data;
		cipher_q.push_back(it);
	endtask

	task automatic drain();
		while (cipher_q.size() != 0 || in_valid || plain_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic compose_program();
		int pos;
		int target;
		int pick;
		int j;
		int starts[$];
		int jumps[$];
		do begin
			starts.delete();
			jumps.delete();
			foreach (prog_img[i]) prog_img[i] = 8'($urandom);
			// One program in ten stays pure noise.
			if ($urandom_range(0, 9) != 0) begin
				pos = 0;
				while (pos < WINDOW_BYTES) begin
					starts.push_back(pos);
					pick = $urandom_range(0, 13);
					case (pick)
						0: begin prog_img[pos] = OP_DEC; pos += 2; end
						1: begin prog_img[pos] = OP_SUB_CL; pos += 2; end
						2: begin prog_img[pos] = OP_ADD_CL; pos += 2; end
						3: begin prog_img[pos] = OP_XOR_CL; pos += 2; end
						4: begin prog_img[pos] = OP_ADD_IMM; pos += 2; end
						5: begin prog_img[pos] = OP_SUB_IMM; pos += 2; end
						6: begin prog_img[pos] = OP_XOR_IMM; pos += 2; end
						7: begin
							prog_img[pos] = OP_ROT_IMM;
							prog_img[pos + 1] = pick_modrm();
							pos += 3;
						end
						8: begin
							prog_img[pos] = OP_ROT_CL;
							prog_img[pos + 1] = pick_modrm();
							pos += 2;
						end
						9: begin prog_img[pos] = OP_NOP; pos += 1; end
						10: begin prog_img[pos] = OP_CLC; pos += 1; end
						11: begin prog_img[pos] = OP_STC; pos += 1; end
						default: begin
							prog_img[pos] = OP_JMP;
							jumps.push_back(pos);
							pos += 2;
						end
					endcase
				end
				foreach (jumps[i]) begin
					j = jumps[i];
					pick = $urandom_range(0, 19);
					if (pick < 12) begin
						target = starts[$urandom_range(0, starts.size() - 1)];
						prog_img[j + 1] = 8'(target - j - 2);
					end else if (pick < 16) begin
						target = $urandom_range(0, 1) ? WINDOW_BYTES + $urandom_range(0, 60)
							: -$urandom_range(1, 70);
						prog_img[j + 1] = 8'(target - j - 2);
					end
				end
				if ($urandom_range(0, 6) == 0)
					prog_img[$urandom_range(0, WINDOW_BYTES - 1)] = 8'($urandom);
			end
		end while (runs_forever());
	endtask

	// Sender: bursts of words with random gaps between them.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				plain_due.push_back(decrypt_byte(byte_item_t'({start_run, data_byte})));
				accepted++;
			end
			if (!in_valid || !in_stall) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (cipher_q.size() != 0) begin
					next_item = cipher_q.pop_front();
					in_valid <= 1'b1;
					start_run <= next_item.start;
					data_byte <= next_item.data;
					if (burst_left == 0) begin
						burst_left <= $urandom_range(1, 24);
						gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: stall behavior switches between none, light and heavy.
	always @(posedge clk) begin
		if (stall_span == 0) begin
			stall_mode <= $urandom_range(0, 2);
			stall_span <= $urandom_range(30, 150);
		end else begin
			stall_span <= stall_span - 1;
		end
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 2) == 0);
			default: out_stall <= ($urandom_range(0, 7) != 0);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (plain_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: plain_byte %h status %0d", plain_byte, status);
			end else begin
				want = plain_due.pop_front();
				if (want.plain !== plain_byte || want.stat !== status) begin
					mismatches++;
					if (mismatches <= 10)
						$display("word %0d: expected plain_byte %h status %0d, got %h %0d",
							checked, want.plain, want.stat, plain_byte, status);
				end
				checked++;
				if (want.stat != ERR_NONE)
					error_words++;
			end
		end
	end

	initial begin
		int n;
		int len;
		int k;
		int random_sent;
		random_sent = 0;
		foreach (prog_mem[i]) prog_mem[i] = 8'h00;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The program store reads as zero after reset, so opcode 00 traps and sticks.
		queue_byte(1'b1, 8'h55);
		queue_byte(1'b0, 8'hAA);
		drain();

		// Every instruction at least once, two forward jumps (the first over junk bytes), and
		// a rotate whose count lies in the spill area past the window.
		prog_img = '{default: OP_NOP};
		prog_img[0] = OP_DEC;      prog_img[1] = 8'h00;
		prog_img[2] = OP_SUB_CL;   prog_img[3] = 8'h00;
		prog_img[4] = OP_ADD_CL;   prog_img[5] = 8'h00;
		prog_img[6] = OP_XOR_CL;   prog_img[7] = 8'h00;
		prog_img[8] = OP_ADD_IMM;  prog_img[9] = 8'h5A;
		prog_img[10] = OP_SUB_IMM; prog_img[11] = 8'hFF;
		prog_img[12] = OP_XOR_IMM; prog_img[13] = 8'h80;
		prog_img[14] = OP_ROT_IMM; prog_img[15] = MODRM_ROL; prog_img[16] = 8'h03;
		prog_img[17] = OP_ROT_IMM; prog_img[18] = MODRM_ROR; prog_img[19] = 8'h0D;
		prog_img[20] = OP_ROT_CL;  prog_img[21] = MODRM_ROR;
		prog_img[22] = OP_ROT_CL;  prog_img[23] = MODRM_ROL;
		prog_img[24] = OP_NOP;     prog_img[25] = OP_CLC;    prog_img[26] = OP_STC;
		prog_img[27] = OP_JMP;     prog_img[28] = 8'h03;
		prog_img[29] = 8'hFF;      prog_img[30] = 8'hFF;     prog_img[31] = 8'hFF;
		prog_img[32] = OP_JMP;     prog_img[33] = 8'h0C;
		prog_img[46] = OP_ROT_IMM; prog_img[47] = MODRM_ROL; prog_img[48] = 8'h05;
		load_image(1'b1, 8'h00);
		queue_byte(1'b1, 8'h00);
		queue_byte(1'b0, 8'hFF);
		queue_byte(1'b0, 8'h80);
		queue_byte(1'b0, 8'h3C);
		drain();

		// New program mid-run: the counter carries on. A backward jump that does not
		// loop, and a jump landing just past the window.
		prog_img = '{default: OP_NOP};
		prog_img[0] = OP_JMP;     prog_img[1] = 8'h04;
		prog_img[2] = OP_ADD_IMM; prog_img[3] = 8'h11;
		prog_img[4] = OP_JMP;     prog_img[5] = 8'h2A;
		prog_img[6] = OP_XOR_IMM; prog_img[7] = 8'hA5;
		prog_img[8] = OP_JMP;     prog_img[9] = 8'hF8;
		load_image(1'b0, 8'h00);
		queue_byte(1'b0, 8'h12);
		queue_byte(1'b0, 8'hFE);
		queue_byte(1'b0, 8'h01);
		drain();

		// Counter at its top value and a jump far below index zero.
		prog_img = '{default: OP_NOP};
		prog_img[0] = OP_ROT_CL; prog_img[1] = MODRM_ROR;
		prog_img[2] = OP_SUB_CL; prog_img[3] = 8'h00;
		prog_img[4] = OP_JMP;    prog_img[5] = 8'h80;
		load_image(1'b1, 8'hFF);
		queue_byte(1'b1, 8'hC3);
		queue_byte(1'b0, 8'h7E);
		drain();

		// Straight run through the whole window; the last XOR takes its operand
		// from the spill area.
		foreach (prog_img[i])
			prog_img[i] = (i % 3 == 0) ? OP_NOP : (i % 3 == 1) ? OP_CLC : OP_STC;
		prog_img[47] = OP_XOR_IMM;
		prog_img[48] = 8'hC3;
		load_image(1'b0, 8'h00);
		queue_byte(1'b0, 8'h00);
		queue_byte(1'b1, 8'hFF);
		queue_byte(1'b0, 8'h5A);
		drain();

		// Trap, then a good program loaded while the error holds; only a new run
		// start clears it.
		prog_img = '{default: OP_NOP};
		prog_img[0] = OP_ADD_IMM; prog_img[1] = 8'h01;
		prog_img[2] = 8'h00;
		load_image(1'b0, 8'h00);
		queue_byte(1'b1, 8'h10);
		queue_byte(1'b0, 8'h20);
		drain();
		prog_img = '{default: OP_NOP};
		prog_img[0] = OP_ADD_CL; prog_img[1] = 8'h00;
		load_image(1'b0, 8'h00);
		queue_byte(1'b0, 8'h30);
		queue_byte(1'b1, 8'h40);
		queue_byte(1'b0, 8'h50);
		drain();

		while (random_sent < 800) begin
			compose_program();
			n = $urandom_range(0, 9);
			load_image(n < 7, (n == 0) ? 8'h00 : (n == 1) ? 8'hFF : 8'($urandom));
			len = $urandom_range(8, 60);
			for (k = 0; k < len; k++)
				queue_byte((k == 0 && $urandom_range(0, 7) != 0) || $urandom_range(0, 24) == 0,
					($urandom_range(0, 15) == 0) ? ($urandom_range(0, 1) ? 8'hFF : 8'h00)
					: 8'($urandom));
			random_sent += len;
			drain();
		end

		repeat (60) @(posedge clk);
		mismatches += plain_due.size();
		$display("Checked %0d decrypted words over %0d loaded programs;", checked, programs);
		$display("%0d of them carried an error status.", error_words);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
